// ===== hw/rtl/srf_pkg.sv =====
// Shared types, constants and command/status structs of the secant root finder.
package srf_pkg;

	localparam int WORD_W    = 32;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int DIV_CNT_W = $clog2(PROD_W);
	localparam int CNT_W     = 8;
	localparam int TOL_W     = 31;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 31;

	localparam logic [WORD_W-1:0] SIGN_BIT = {1'b1, {(WORD_W-1){1'b0}}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'd1;

	localparam logic [CNT_W-1:0] ITER_LIMIT_RST = 8'd20;
	localparam logic [TOL_W-1:0] TOLERANCE_RST  = 31'd7;

	// input mode and result kind codes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_VALUE = 1'b1;
	localparam logic KIND_REQ   = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_CONV  = 2'd0,
		STAT_LIMIT = 2'd1,
		STAT_FLAT  = 2'd2
	} stat_t;

	typedef enum logic {
		XSEL_OLD = 1'b0,
		XSEL_NEW = 1'b1
	} xsel_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_OLD  = 2'd1,
		PH_NEW  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_DECIDE,
		ST_MUL,
		ST_DIV,
		ST_UPD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic  kind;
		stat_t status;
		xsel_t xsel;
	} srf_res_t;

	typedef struct packed {
		logic     load_in;
		logic     start;
		logic     save_fold;
		logic     inc_count;
		logic     mul;
		logic     div_step;
		logic     update;
		logic     out_load;
		srf_res_t res;
	} srf_cmd_t;

	typedef struct packed {
		logic mode;
		logic cnt_ge;
		logic f_small;
		logic f_flat;
		logic div_last;
	} srf_sts_t;

endpackage

// ===== hw/rtl/srf_dp.sv =====
// Datapath of the secant root finder: guesses, config, multiplier, serial divider, output item.
module srf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [srf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srf_pkg::CFG_DAT_W-1:0]       cfg_data,
	input  logic                                mode,
	input  logic signed [srf_pkg::WORD_W-1:0]   x_start,
	input  logic signed [srf_pkg::WORD_W-1:0]   x_prev_start,
	input  logic signed [srf_pkg::WORD_W-1:0]   f_value,
	input  srf_pkg::srf_cmd_t                   cmd,
	output srf_pkg::srf_sts_t                   sts,
	output logic                                kind,
	output logic signed [srf_pkg::WORD_W-1:0]   x_value,
	output logic [1:0]                          status
);

	logic [srf_pkg::CNT_W-1:0]     iter_limit_q;
	logic [srf_pkg::TOL_W-1:0]     tol_q;
	logic [srf_pkg::WORD_W-1:0]    guess_new_q, guess_old_q, fold_q;
	logic [srf_pkg::CNT_W-1:0]     count_q;
	logic                          mode_q;
	logic [srf_pkg::WORD_W-1:0]    xin_q, xpin_q, f_q;
	logic [srf_pkg::PROD_W-1:0]    num_q;
	logic [srf_pkg::WORD_W-1:0]    rem_q, den_q;
	logic                          neg_q;
	logic [srf_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic                          kind_q;
	logic [srf_pkg::WORD_W-1:0]    x_q;
	srf_pkg::stat_t                status_q;

	logic [srf_pkg::WORD_W-1:0] fmag, dmag, denmag;
	logic [srf_pkg::WORD_W-1:0] ua, ub, fa, fb;
	logic                       dneg, denneg;
	logic [srf_pkg::WORD_W:0]   trial, trial_sub;
	logic [srf_pkg::WORD_W-1:0] u, u_next;

	// magnitudes and signs of the secant terms
	always_comb begin
		fmag   = f_q[srf_pkg::WORD_W-1] ? (~f_q + 1'b1) : f_q;
		ua     = guess_new_q ^ srf_pkg::SIGN_BIT;
		ub     = guess_old_q ^ srf_pkg::SIGN_BIT;
		dneg   = (ua < ub);
		dmag   = dneg ? (ub - ua) : (ua - ub);
		fa     = f_q ^ srf_pkg::SIGN_BIT;
		fb     = fold_q ^ srf_pkg::SIGN_BIT;
		denneg = (fa < fb);
		denmag = denneg ? (fb - fa) : (fa - fb);
	end

	// one restoring division step
	always_comb begin
		trial     = {rem_q, num_q[srf_pkg::PROD_W-1]};
		trial_sub = trial - {1'b0, den_q};
	end

	// saturating x - step in offset binary
	always_comb begin
		u = guess_new_q ^ srf_pkg::SIGN_BIT;
		if (!neg_q) begin
			if (num_q > {{srf_pkg::WORD_W{1'b0}}, u})
				u_next = '0;
			else
				u_next = u - num_q[srf_pkg::WORD_W-1:0];
		end else begin
			if (num_q > {{srf_pkg::WORD_W{1'b0}}, ~u})
				u_next = '1;
			else
				u_next = u + num_q[srf_pkg::WORD_W-1:0];
		end
	end

	// status to the controller
	always_comb begin
		sts.mode     = mode_q;
		sts.cnt_ge   = (count_q >= iter_limit_q);
		sts.f_small  = (fmag < {1'b0, tol_q});
		sts.f_flat   = (f_q == fold_q);
		sts.div_last = (div_cnt_q == {srf_pkg::DIV_CNT_W{1'b1}});
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit_q <= srf_pkg::ITER_LIMIT_RST;
			tol_q        <= srf_pkg::TOLERANCE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				srf_pkg::CFG_ITER_LIMIT: iter_limit_q <= cfg_data[srf_pkg::CNT_W-1:0];
				srf_pkg::CFG_TOLERANCE:  tol_q <= cfg_data[srf_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guess_new_q <= '0;
			guess_old_q <= '0;
			fold_q      <= '0;
			count_q     <= '0;
		end else begin
			if (cmd.start) begin
				guess_new_q <= xin_q;
				guess_old_q <= xpin_q;
				count_q     <= '0;
			end
			if (cmd.save_fold)
				fold_q <= f_q;
			if (cmd.inc_count && (count_q != {srf_pkg::CNT_W{1'b1}}))
				count_q <= count_q + 1'b1;
			if (cmd.update) begin
				guess_old_q <= guess_new_q;
				fold_q      <= f_q;
				guess_new_q <= u_next ^ srf_pkg::SIGN_BIT;
			end
		end
	end

	// captured input item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= mode;
			xin_q  <= x_start;
			xpin_q <= x_prev_start;
			f_q    <= f_value;
		end
	end

	// product, then serial quotient in num_q
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			num_q <= fmag * dmag;
			den_q <= denmag;
			rem_q <= '0;
			neg_q <= f_q[srf_pkg::WORD_W-1] ^ dneg ^ denneg;
		end else if (cmd.div_step) begin
			if (!trial_sub[srf_pkg::WORD_W]) begin
				rem_q <= trial_sub[srf_pkg::WORD_W-1:0];
				num_q <= {num_q[srf_pkg::PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[srf_pkg::WORD_W-1:0];
				num_q <= {num_q[srf_pkg::PROD_W-2:0], 1'b0};
			end
		end
	end

	// divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= '0;
		else if (cmd.mul)
			div_cnt_q <= '0;
		else if (cmd.div_step)
			div_cnt_q <= div_cnt_q + 1'b1;
	end

	// output item register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q   <= cmd.res.kind;
			status_q <= cmd.res.status;
			x_q      <= (cmd.res.xsel == srf_pkg::XSEL_NEW) ? guess_new_q : guess_old_q;
		end
	end

	assign kind    = kind_q;
	assign x_value = x_q;
	assign status  = status_q;

endmodule

// ===== hw/rtl/srf_ctrl.sv =====
// Controller of the secant root finder: search phase, sequencing and output handshake.
module srf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	input  srf_pkg::srf_sts_t sts,
	output srf_pkg::srf_cmd_t cmd
);

	srf_pkg::state_t   state_q, state_d;
	srf_pkg::phase_t   phase_q, phase_d;
	srf_pkg::srf_res_t res_q, res_d;
	logic              out_valid_q, out_valid_d;

	// state, phase and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srf_pkg::ST_WAIT;
			phase_q     <= srf_pkg::PH_IDLE;
			res_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			res_q       <= res_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		res_d       = res_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.res     = res_q;
		case (state_q)
			srf_pkg::ST_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = srf_pkg::ST_DECIDE;
				end
			end
			srf_pkg::ST_DECIDE: begin
				if (sts.mode == srf_pkg::MODE_START) begin
					// restart: ask for f at the older guess
					cmd.start = 1'b1;
					phase_d   = srf_pkg::PH_OLD;
					res_d     = '{srf_pkg::KIND_REQ, srf_pkg::STAT_CONV, srf_pkg::XSEL_OLD};
					state_d   = srf_pkg::ST_EMIT;
				end else begin
					case (phase_q)
						srf_pkg::PH_OLD: begin
							cmd.save_fold = 1'b1;
							state_d       = srf_pkg::ST_EMIT;
							if (sts.cnt_ge) begin
								phase_d = srf_pkg::PH_IDLE;
								res_d   = '{srf_pkg::KIND_DONE, srf_pkg::STAT_LIMIT,
									srf_pkg::XSEL_NEW};
							end else begin
								phase_d = srf_pkg::PH_NEW;
								res_d   = '{srf_pkg::KIND_REQ, srf_pkg::STAT_CONV,
									srf_pkg::XSEL_NEW};
							end
						end
						srf_pkg::PH_NEW: begin
							cmd.inc_count = 1'b1;
							if (sts.f_small) begin
								phase_d = srf_pkg::PH_IDLE;
								res_d   = '{srf_pkg::KIND_DONE, srf_pkg::STAT_CONV,
									srf_pkg::XSEL_NEW};
								state_d = srf_pkg::ST_EMIT;
							end else if (sts.f_flat) begin
								phase_d = srf_pkg::PH_IDLE;
								res_d   = '{srf_pkg::KIND_DONE, srf_pkg::STAT_FLAT,
									srf_pkg::XSEL_NEW};
								state_d = srf_pkg::ST_EMIT;
							end else begin
								state_d = srf_pkg::ST_MUL;
							end
						end
						default: state_d = srf_pkg::ST_WAIT;
					endcase
				end
			end
			srf_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = srf_pkg::ST_DIV;
			end
			srf_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = srf_pkg::ST_UPD;
			end
			srf_pkg::ST_UPD: begin
				// count was bumped in the decide step
				cmd.update = 1'b1;
				state_d    = srf_pkg::ST_EMIT;
				if (sts.cnt_ge) begin
					phase_d = srf_pkg::PH_IDLE;
					res_d   = '{srf_pkg::KIND_DONE, srf_pkg::STAT_LIMIT, srf_pkg::XSEL_NEW};
				end else begin
					res_d   = '{srf_pkg::KIND_REQ, srf_pkg::STAT_CONV, srf_pkg::XSEL_NEW};
				end
			end
			srf_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = srf_pkg::ST_WAIT;
				end
			end
			default: state_d = srf_pkg::ST_WAIT;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/secant_root_finder.sv =====
// Top level of the secant root finder: controller, datapath and checks.
//
// Usage: a start item (mode 0) loads the newer and older guesses and the block
// answers with a request (kind 0) for f at the older guess. Each value item
// (mode 1) returns f at the last requested point; the block answers with the
// next request or a finished item (kind 1) carrying the estimate and status
// (converged, iteration limit, zero slope). A value item while no search runs
// is dropped. A start item always restarts the search.
// Config: cfg_valid/cfg_index/cfg_data write the iteration limit (0) or the
// tolerance (1); cfg_ready is always high and writes belong in idle periods.
// A request at a guess already held goes through the decide and emit states
// after its item is taken. An update adds the multiply state for the 32x32
// product and the restoring divider's 64 quotient bits, one bit per cycle.
// One item is worked at a time; in_ready is high while waiting for an item,
// also while the last result still sits in the output register.
// If out_ready stays low, the next result waits until that register empties.
// Reset clears the search (no search running) and restores an iteration
// limit of 20 and a tolerance of 7; no clearing pass is needed.
module secant_root_finder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [srf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srf_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic signed [srf_pkg::WORD_W-1:0] x_start,
	input  logic signed [srf_pkg::WORD_W-1:0] x_prev_start,
	input  logic signed [srf_pkg::WORD_W-1:0] f_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              kind,
	output logic signed [srf_pkg::WORD_W-1:0] x_value,
	output logic [1:0]                        status
);

	srf_pkg::srf_cmd_t cmd;
	srf_pkg::srf_sts_t sts;

	assign cfg_ready = 1'b1;

	srf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	srf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.x_start      (x_start),
		.x_prev_start (x_prev_start),
		.f_value      (f_value),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.x_value      (x_value),
		.status       (status)
	);

	// an item taken is worked before the next one is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous item still in work");

	// output register is never overwritten while it holds an unread item
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output item overwritten");

	// the last divide step is followed by the guess update
	a_div_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && sts.div_last |=> cmd.update)
		else $error("divider finished without update");

	// requests carry a zero status
	a_req_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == srf_pkg::KIND_REQ) |-> (status == srf_pkg::STAT_CONV))
		else $error("request item with nonzero status");

endmodule
